FILE: hw/rtl/calendar_clock_tick_unit_assert.svh
// assertion macros shared by the checker
`ifndef CALENDAR_CLOCK_TICK_UNIT_ASSERT_SVH
`define CALENDAR_CLOCK_TICK_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define CCT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("calendar clock check failed");

// next-cycle implication, held off during reset
`define CCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("calendar clock check failed");

// next-cycle implication that also covers the reset cycles
`define CCT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("calendar clock check failed");

`endif

FILE: hw/rtl/cct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cct_pkg;

    localparam int unsigned SEC_MAX     = 59;
    localparam int unsigned MIN_MAX     = 59;
    localparam int unsigned HOUR_MAX    = 23;
    localparam int unsigned WDAY_MAX    = 6;
    localparam int unsigned MONTH_MAX   = 12;
    localparam int unsigned LONG_MONTH  = 31;
    localparam int unsigned SHORT_MONTH = 30;
    localparam int unsigned FEB_DAYS    = 28;

    localparam int unsigned MASK_W = 6;

    // change mask bit positions
    localparam int unsigned MASK_SEC   = 0;
    localparam int unsigned MASK_MIN   = 1;
    localparam int unsigned MASK_HAND  = 2;
    localparam int unsigned MASK_DAY   = 3;
    localparam int unsigned MASK_MONTH = 4;
    localparam int unsigned MASK_YEAR  = 5;

    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_LOAD = 1'b1
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [5:0]  load_second;
        logic [5:0]  load_minute;
        logic [4:0]  load_hour;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [15:0] load_year;
        logic [2:0]  load_weekday;
    } t_in_item;

    typedef struct packed {
        logic [5:0]        second;
        logic [5:0]        minute;
        logic [4:0]        hour;
        logic [4:0]        day;
        logic [3:0]        month;
        logic [15:0]       year;
        logic [2:0]        weekday;
        logic [MASK_W-1:0] change_mask;
    } t_out_item;

    // months outside 1..12 take the february length
    function automatic logic [4:0] month_length(input logic [3:0] m, input logic [15:0] y);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'(LONG_MONTH);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'(SHORT_MONTH);
            default: len = (y[1:0] == 2'b00) ? 5'(FEB_DAYS + 1) : 5'(FEB_DAYS);
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cct_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cct_in_if;
    logic              valid;
    logic              ready;
    cct_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cct_out_if;
    logic               valid;
    logic               ready;
    cct_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/calendar_clock_tick_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   beat contents
// i_in      in    action, load_second .. load_weekday
// o_out     out   second .. weekday, change_mask
//
// one beat in per cycle while i_in.ready is high; each beat gives one result beat in the next cycle
// the carry chain from second to year is one pass of logic on the state registers
// i_in.ready drops while a result waits in the output register and o_out.ready is low
// synchronous reset clears the calendar to all zero and empties the output register
// i_in.ready is held low while reset is asserted

module calendar_clock_tick_unit (
    input  wire  i_clk,
    input  wire  i_rst_n,
    cct_in_if.sink    i_in,
    cct_out_if.source o_out
);
    import cct_pkg::*;

    logic [5:0]  r_sec, r_min;
    logic [4:0]  r_hour, r_day;
    logic [3:0]  r_month;
    logic [15:0] r_year;
    logic [2:0]  r_wday;
    logic        r_out_valid;
    t_out_item   r_out_data;

    logic [5:0]        n_sec, n_min;
    logic [4:0]        n_hour, n_day;
    logic [3:0]        n_month;
    logic [15:0]       n_year;
    logic [2:0]        n_wday;
    logic [MASK_W-1:0] n_mask;

    logic [6:0] sec_inc, min_inc;
    logic [5:0] hour_inc, day_inc;
    logic [4:0] month_inc;
    logic [3:0] wday_inc;
    logic [4:0] cur_len;
    logic       accept;

    assign i_in.ready  = i_rst_n && (!r_out_valid || o_out.ready);
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // increments kept one bit wider so out-of-range counts still roll over
    assign sec_inc   = {1'b0, r_sec} + 7'd1;
    assign min_inc   = {1'b0, r_min} + 7'd1;
    assign hour_inc  = {1'b0, r_hour} + 6'd1;
    assign day_inc   = {1'b0, r_day} + 6'd1;
    assign month_inc = {1'b0, r_month} + 5'd1;
    assign wday_inc  = {1'b0, r_wday} + 4'd1;
    assign cur_len   = month_length(r_month, r_year);

    always_comb begin
        n_sec   = r_sec;
        n_min   = r_min;
        n_hour  = r_hour;
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_wday  = r_wday;
        n_mask  = '0;
        if (i_in.data.action == ACT_LOAD) begin
            n_sec   = i_in.data.load_second;
            n_min   = i_in.data.load_minute;
            n_hour  = i_in.data.load_hour;
            n_day   = i_in.data.load_day;
            n_month = i_in.data.load_month;
            n_year  = i_in.data.load_year;
            n_wday  = i_in.data.load_weekday;
        end else begin
            n_mask[MASK_SEC] = 1'b1;
            n_sec = sec_inc[5:0];
            if (sec_inc > 7'(SEC_MAX)) begin
                n_sec = '0;
                n_mask[MASK_MIN]  = 1'b1;
                n_mask[MASK_HAND] = 1'b1;
                n_min = min_inc[5:0];
                if (min_inc > 7'(MIN_MAX)) begin
                    n_min  = '0;
                    n_hour = hour_inc[4:0];
                    if (hour_inc > 6'(HOUR_MAX)) begin
                        n_hour = '0;
                        n_mask[MASK_DAY] = 1'b1;
                        n_wday = (wday_inc > 4'(WDAY_MAX)) ? 3'd0 : wday_inc[2:0];
                        n_day  = day_inc[4:0];
                        if (day_inc > {1'b0, cur_len}) begin
                            n_day = 5'd1;
                            n_mask[MASK_MONTH] = 1'b1;
                            n_month = month_inc[3:0];
                            if (month_inc > 5'(MONTH_MAX)) begin
                                n_month = 4'd1;
                                n_mask[MASK_YEAR] = 1'b1;
                                n_year = r_year + 16'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec       <= '0;
            r_min       <= '0;
            r_hour      <= '0;
            r_day       <= '0;
            r_month     <= '0;
            r_year      <= '0;
            r_wday      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_sec       <= n_sec;
                r_min       <= n_min;
                r_hour      <= n_hour;
                r_day       <= n_day;
                r_month     <= n_month;
                r_year      <= n_year;
                r_wday      <= n_wday;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= '{second: n_sec, minute: n_min, hour: n_hour, day: n_day,
                            month: n_month, year: n_year, weekday: n_wday,
                            change_mask: n_mask};
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_clock_tick_unit_assert.svh"

module cct_checker (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     i_in_valid,
    input wire                     i_in_ready,
    input wire cct_pkg::t_in_item  i_in_data,
    input wire                     i_out_valid,
    input wire                     i_out_ready,
    input wire cct_pkg::t_out_item i_out_data
);
    import cct_pkg::*;

    logic in_beat, out_stall, is_load;

    assign in_beat   = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;
    assign is_load   = i_in_data.action == ACT_LOAD;

    // a waiting result holds still
    `CCT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(i_out_data))

    // no new beat is taken while the output register is blocked
    `CCT_ASSERT_NOW(a_in_blocked, i_clk, i_rst_n, out_stall, !i_in_ready)

    // a load shows its second and year fields next cycle with an empty mask
    `CCT_ASSERT_NEXT(a_load_result, i_clk, i_rst_n, in_beat && is_load,
                     i_out_valid && i_out_data.change_mask == '0 &&
                     i_out_data.second == $past(i_in_data.load_second) &&
                     i_out_data.year == $past(i_in_data.load_year))

    // a tick always flags the second and a rollover always flags the hand
    `CCT_ASSERT_NEXT(a_tick_mask, i_clk, i_rst_n, in_beat && !is_load,
                     i_out_valid && i_out_data.change_mask[MASK_SEC] &&
                     (i_out_data.change_mask[MASK_MIN] == i_out_data.change_mask[MASK_HAND]))

    // reset empties the output register
    `CCT_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind calendar_clock_tick_unit cct_checker u_cct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_data   (i_in.data),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire
